@@ rtl/core/line_keyword_filter_assert.svh @@
// ---------------------------------------------------------------------------
// line_keyword_filter_assert.svh
// Assertion macros for the line keyword filter. Define ASSERT_OFF to drop
// every check from the build.
// ---------------------------------------------------------------------------
`ifndef LINE_KEYWORD_FILTER_ASSERT_SVH
`define LINE_KEYWORD_FILTER_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define LKF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("line_keyword_filter: check failed");
// next-cycle implication
`define LKF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("line_keyword_filter: check failed");
`else
`define LKF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LKF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/lkf_pkg.sv @@
// ---------------------------------------------------------------------------
// lkf_pkg
// Shared types, constants and helpers of the line keyword filter.
// ---------------------------------------------------------------------------
package lkf_pkg;

	localparam int LINE_LIMIT_DEF       = 128;
	localparam int KEY_LIMIT_DEF        = 32;
	localparam int BYTES_PER_RESULT_DEF = 8;

	localparam int KEY_WORDS  = 4;
	localparam int ADDR_W     = 6;
	localparam int DATA_W     = 64;
	localparam int KEY_LEN_W  = 6;

	localparam logic [7:0] NEWLINE = 8'd10;
	localparam logic [7:0] ASCII_UA = 8'h41;
	localparam logic [7:0] ASCII_UZ = 8'h5A;
	localparam logic [7:0] ASCII_LA = 8'h61;

	localparam logic REQ_DATA = 1'b0;
	localparam logic REQ_END  = 1'b1;

	localparam logic KIND_CHUNK  = 1'b0;
	localparam logic KIND_NOTICE = 1'b1;

	typedef enum logic [2:0] {
		REG_KEY_LEN = 3'd0,
		REG_KEY_W0  = 3'd1,
		REG_KEY_W1  = 3'd2,
		REG_KEY_W2  = 3'd3,
		REG_KEY_W3  = 3'd4
	} reg_idx_t;

	typedef logic [KEY_WORDS-1:0][63:0] key_words_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
	} byte_item_t;

	typedef struct packed {
		logic        kind;
		logic [63:0] chunk;
		logic [3:0]  chunk_bytes;
		logic        last_in_run;
	} res_item_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_NOTICE = 2'd1,
		ST_EMIT   = 2'd2
	} lkf_state_t;

	// controller -> datapath
	typedef struct packed {
		logic take;
		logic notice_load;
		logic advance;
	} lkf_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic want_emit;
		logic want_notice;
		logic out_free;
		logic emit_last;
	} lkf_stat_t;

	function automatic logic [7:0] fold_lower(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= ASCII_UA && c <= ASCII_UZ) begin
			r = c - ASCII_UA + ASCII_LA;
		end
		return r;
	endfunction

endpackage

@@ rtl/core/lkf_ram.sv @@
// ---------------------------------------------------------------------------
// lkf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lkf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/lkf_regs.sv @@
// ---------------------------------------------------------------------------
// lkf_regs
// APB-style register file: keyword length and four 64-bit keyword words.
// ---------------------------------------------------------------------------
module lkf_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lkf_pkg::ADDR_W-1:0]     paddr,
	input  logic [lkf_pkg::DATA_W-1:0]     pwdata,
	output logic [lkf_pkg::DATA_W-1:0]     prdata,
	output logic                           pready,
	output logic [lkf_pkg::KEY_LEN_W-1:0]  key_len,
	output lkf_pkg::key_words_t            key_words
);
	import lkf_pkg::*;

	logic [KEY_LEN_W-1:0] key_len_q;
	key_words_t           key_words_q;
	reg_idx_t             idx;
	logic                 wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q   <= '0;
			key_words_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_KEY_LEN: key_len_q      <= pwdata[KEY_LEN_W-1:0];
				REG_KEY_W0:  key_words_q[0] <= pwdata;
				REG_KEY_W1:  key_words_q[1] <= pwdata;
				REG_KEY_W2:  key_words_q[2] <= pwdata;
				REG_KEY_W3:  key_words_q[3] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_KEY_LEN: prdata = DATA_W'(key_len_q);
			REG_KEY_W0:  prdata = key_words_q[0];
			REG_KEY_W1:  prdata = key_words_q[1];
			REG_KEY_W2:  prdata = key_words_q[2];
			REG_KEY_W3:  prdata = key_words_q[3];
			default:     prdata = '0;
		endcase
	end

	assign key_len   = key_len_q;
	assign key_words = key_words_q;

endmodule

@@ rtl/core/lkf_ctrl.sv @@
// ---------------------------------------------------------------------------
// lkf_ctrl
// Controller: takes bytes while idle, then sequences a notice or a line
// emission through the datapath.
// ---------------------------------------------------------------------------
module lkf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  lkf_pkg::lkf_stat_t stat,
	output lkf_pkg::lkf_cmd_t  cmd
);
	import lkf_pkg::*;

	lkf_state_t state_q;
	lkf_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (byte_valid) begin
					if (stat.want_notice) begin
						state_nx = ST_NOTICE;
					end else if (stat.want_emit) begin
						state_nx = ST_EMIT;
					end
				end
			end
			ST_NOTICE: begin
				if (stat.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (stat.out_free && stat.emit_last) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		byte_ready      = 1'b0;
		cmd.take        = 1'b0;
		cmd.notice_load = 1'b0;
		cmd.advance     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				byte_ready = 1'b1;
				cmd.take   = byte_valid;
			end
			ST_NOTICE: cmd.notice_load = stat.out_free;
			ST_EMIT:   cmd.advance     = stat.out_free;
			default: ;
		endcase
	end

endmodule

@@ rtl/core/lkf_dp.sv @@
// ---------------------------------------------------------------------------
// lkf_dp
// Datapath: line store, match window, line state, chunk packer and the
// result register.
// ---------------------------------------------------------------------------
module lkf_dp #(
	parameter int LINE_LIMIT       = lkf_pkg::LINE_LIMIT_DEF,
	parameter int KEY_LIMIT        = lkf_pkg::KEY_LIMIT_DEF,
	parameter int BYTES_PER_RESULT = lkf_pkg::BYTES_PER_RESULT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lkf_pkg::byte_item_t           byte_item,
	input  lkf_pkg::lkf_cmd_t             cmd,
	output lkf_pkg::lkf_stat_t            stat,
	input  logic [lkf_pkg::KEY_LEN_W-1:0] key_len,
	input  lkf_pkg::key_words_t           key_words,
	output logic                          res_valid,
	input  logic                          res_ready,
	output lkf_pkg::res_item_t            res_item
);
	import lkf_pkg::*;

	localparam int CNTW = $clog2(LINE_LIMIT + 1);
	localparam int CW   = $clog2(LINE_LIMIT + 2);
	localparam int AW   = $clog2(LINE_LIMIT);
	localparam int NW   = $clog2(BYTES_PER_RESULT + 1);

	// line state
	logic [CNTW-1:0]                cnt_q;
	logic                           drop_q;
	logic                           found_q;
	logic [KEY_LIMIT-1:0][7:0]      win_q;
	logic [KEY_LIMIT-1:0][7:0]      win_nx;

	// emission
	logic [CNTW-1:0]                elen_q;
	logic [CW-1:0]                  etot_q;
	logic [CW-1:0]                  pos_q;
	logic                           bv_s1;
	logic                           nl_s1;
	logic                           last_s1;
	logic [BYTES_PER_RESULT-1:0][7:0] acc_q;
	logic [BYTES_PER_RESULT-1:0][7:0] acc_nx;
	logic [NW-1:0]                  an_q;
	logic [NW-1:0]                  an_inc;
	logic [7:0]                     emit_byte;
	logic                           fetch;
	logic                           fetch_ram;
	logic                           load_chunk;

	logic                           res_valid_q;
	res_item_t                      res_item_q;

	logic                           is_end;
	logic                           is_nl;
	logic                           full;
	logic                           store_en;
	logic                           hit;
	logic [KEY_LEN_W-1:0]           klen;
	logic [CNTW-1:0]                cnt_inc;
	logic [KEY_LIMIT-1:0]           ok;
	logic [7:0]                     rdata;

	assign is_end   = (byte_item.req_type == REQ_END);
	assign is_nl    = (byte_item.data_byte == NEWLINE);
	assign full     = (cnt_q >= CNTW'(LINE_LIMIT));
	assign store_en = cmd.take && !is_end && !drop_q && !is_nl && !full;
	assign cnt_inc  = cnt_q + CNTW'(1);

	assign stat.want_notice = !is_end && !drop_q && !is_nl && full;
	assign stat.want_emit   = !drop_q && (cnt_q != '0) && found_q && (is_end || is_nl);

	// keyword compare over the window as it will stand after this byte
	assign klen = (key_len > KEY_LEN_W'(KEY_LIMIT)) ? KEY_LEN_W'(KEY_LIMIT) : key_len;

	always_comb begin
		logic [4:0] kidx;
		logic [7:0] kb;
		win_nx[0] = fold_lower(byte_item.data_byte);
		for (int j = 1; j < KEY_LIMIT; j++) begin
			win_nx[j] = win_q[j-1];
		end
		for (int j = 0; j < KEY_LIMIT; j++) begin
			kidx  = 5'(klen - KEY_LEN_W'(1) - KEY_LEN_W'(j));
			kb    = fold_lower(key_words[kidx[4:3]][kidx[2:0]*8 +: 8]);
			ok[j] = (KEY_LEN_W'(j) >= klen) || (win_nx[j] == kb);
		end
		hit = (klen != '0) && (32'(cnt_inc) >= 32'(klen)) && (&ok);
	end

	lkf_ram #(
		.WIDTH(8),
		.DEPTH(LINE_LIMIT)
	) u_line_store (
		.clk  (clk),
		.we   (store_en),
		.waddr(cnt_q[AW-1:0]),
		.wdata(byte_item.data_byte),
		.re   (fetch_ram),
		.raddr(pos_q[AW-1:0]),
		.rdata(rdata)
	);

	// emission: fetch stage reads the store, append stage packs the chunk
	assign fetch      = (pos_q < etot_q);
	assign fetch_ram  = cmd.advance && fetch && (pos_q < CW'(elen_q));
	assign emit_byte  = nl_s1 ? NEWLINE : rdata;
	assign an_inc     = an_q + NW'(1);
	assign load_chunk = cmd.advance && bv_s1 &&
		((an_inc == NW'(BYTES_PER_RESULT)) || last_s1);

	always_comb begin
		acc_nx = acc_q;
		for (int k = 0; k < BYTES_PER_RESULT; k++) begin
			if (an_q == NW'(k)) begin
				acc_nx[k] = emit_byte;
			end
		end
	end

	assign stat.out_free  = !res_valid_q || res_ready;
	assign stat.emit_last = bv_s1 && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			drop_q      <= 1'b0;
			found_q     <= 1'b0;
			win_q       <= '0;
			pos_q       <= '0;
			bv_s1       <= 1'b0;
			an_q        <= '0;
			acc_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				pos_q <= '0;
				bv_s1 <= 1'b0;
				an_q  <= '0;
				acc_q <= '0;
				if (is_end) begin
					cnt_q   <= '0;
					found_q <= 1'b0;
					win_q   <= '0;
					drop_q  <= 1'b0;
				end else if (drop_q) begin
					if (is_nl) begin
						drop_q  <= 1'b0;
						cnt_q   <= '0;
						found_q <= 1'b0;
						win_q   <= '0;
					end
				end else if (is_nl) begin
					cnt_q   <= '0;
					found_q <= 1'b0;
					win_q   <= '0;
				end else if (full) begin
					// overflow byte is not stored; drop up to the next newline
					drop_q  <= 1'b1;
					cnt_q   <= '0;
					found_q <= 1'b0;
					win_q   <= '0;
				end else begin
					cnt_q <= cnt_inc;
					win_q <= win_nx;
					if (hit) begin
						found_q <= 1'b1;
					end
				end
			end
			if (cmd.advance) begin
				bv_s1 <= fetch;
				if (fetch) begin
					pos_q <= pos_q + CW'(1);
				end
				if (bv_s1) begin
					if (load_chunk) begin
						acc_q <= '0;
						an_q  <= '0;
					end else begin
						acc_q <= acc_nx;
						an_q  <= an_inc;
					end
				end
			end
			if (load_chunk || cmd.notice_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			elen_q <= cnt_q;
			etot_q <= CW'(cnt_q) + ((!is_end && is_nl) ? CW'(1) : CW'(0));
		end
		if (cmd.advance && fetch) begin
			nl_s1   <= (pos_q >= CW'(elen_q));
			last_s1 <= (pos_q == etot_q - CW'(1));
		end
		if (cmd.notice_load) begin
			res_item_q.kind        <= KIND_NOTICE;
			res_item_q.chunk       <= '0;
			res_item_q.chunk_bytes <= '0;
			res_item_q.last_in_run <= 1'b1;
		end else if (load_chunk) begin
			res_item_q.kind        <= KIND_CHUNK;
			res_item_q.chunk       <= 64'(acc_nx);
			res_item_q.chunk_bytes <= 4'(an_inc);
			res_item_q.last_in_run <= last_s1;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

endmodule

@@ rtl/core/line_keyword_filter.sv @@
// ---------------------------------------------------------------------------
// line_keyword_filter
// Case-insensitive keyword line filter over a byte stream.
// ---------------------------------------------------------------------------
// Input channel (byte_valid/byte_ready/byte_item) carries one byte or an
// end-of-input marker per transfer. Output channel (res_valid/res_ready/
// res_item) carries chunks of a matching line, or a line-too-long notice.
// Keyword length and keyword words are written over the APB port.
//
// Ordinary bytes are taken one per cycle. A byte that overflows the line
// moves the controller to its notice state, which loads the notice into
// the result register once the output is free; the next byte is taken
// after that. A newline or end-of-input on a matching line starts an
// emission that reads the line store one byte per cycle while the output
// is free; the input stays closed until the last byte is packed. The single
// read port of the line store sets that pace.
// While the receiver stalls, the result register holds its item and the
// emission stops; a waiting result does not block further byte transfers
// unless they themselves produce a result.
// Reset clears the keyword, line count, match state and drop mode; the line
// store needs no clearing.
// ---------------------------------------------------------------------------
module line_keyword_filter #(
	parameter int LINE_LIMIT       = lkf_pkg::LINE_LIMIT_DEF,
	parameter int KEY_LIMIT        = lkf_pkg::KEY_LIMIT_DEF,
	parameter int BYTES_PER_RESULT = lkf_pkg::BYTES_PER_RESULT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       byte_valid,
	output logic                       byte_ready,
	input  lkf_pkg::byte_item_t        byte_item,
	output logic                       res_valid,
	input  logic                       res_ready,
	output lkf_pkg::res_item_t         res_item,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lkf_pkg::ADDR_W-1:0] paddr,
	input  logic [lkf_pkg::DATA_W-1:0] pwdata,
	output logic [lkf_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import lkf_pkg::*;

	`include "line_keyword_filter_assert.svh"

	lkf_cmd_t             cmd;
	lkf_stat_t            stat;
	logic [KEY_LEN_W-1:0] key_len;
	key_words_t           key_words;

	lkf_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.key_len  (key_len),
		.key_words(key_words)
	);

	lkf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lkf_dp #(
		.LINE_LIMIT      (LINE_LIMIT),
		.KEY_LIMIT       (KEY_LIMIT),
		.BYTES_PER_RESULT(BYTES_PER_RESULT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_item(byte_item),
		.cmd      (cmd),
		.stat     (stat),
		.key_len  (key_len),
		.key_words(key_words),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_item (res_item)
	);

	// no byte is taken while a line is being sent
	`LKF_ASSERT_IMP(a_no_take_in_emit, clk, arst_n, cmd.advance || cmd.notice_load, !byte_ready)
	// a notice is always a single, empty result
	`LKF_ASSERT_IMP(a_notice_shape, clk, arst_n, res_valid && res_item.kind == KIND_NOTICE, res_item.chunk_bytes == 4'd0 && res_item.last_in_run)
	// chunks never exceed the configured size
	`LKF_ASSERT_IMP(a_chunk_size, clk, arst_n, res_valid && res_item.kind == KIND_CHUNK, res_item.chunk_bytes != 4'd0 && 32'(res_item.chunk_bytes) <= BYTES_PER_RESULT)
	// finishing the last byte of a line reopens the input
	`LKF_ASSERT_NXT(a_emit_done, clk, arst_n, cmd.advance && stat.emit_last, byte_ready)

endmodule
